/* rtl/hpq_pkg.sv */
// Package for the binary max heap queue: sizes, codes and the payload structs.
// It has no dependencies. Every other file of the block imports it.
package hpq_pkg;

    localparam int DEPTH   = 128;
    localparam int KEY_W   = 32;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int ECNT_W  = 8;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic                    action;
        logic signed [KEY_W-1:0] key_in;
    } t_cmd;

    typedef struct packed {
        logic signed [KEY_W-1:0] max_key;
        logic                    max_valid;
        logic [ECNT_W-1:0]       entry_count;
        logic [1:0]              status;
    } t_result;

    typedef struct packed {
        logic                    ins;
        logic                    rem;
        logic signed [KEY_W-1:0] key;
    } t_cell_cmd;

endpackage

/* rtl/binary_max_heap_queue_top.sv */
// Top level of the max priority queue: a row of hpq_cell keys kept in descending order.
// Depends on hpq_pkg and hpq_cell.
//
//   Channel  | Ports               | Handshake
//   command  | start, i_cmd, busy  | taken at a rising edge with start high and busy low
//   result   | o_strobe, o_result  | shown for one cycle, taken at the edge that ends it
//
// The row updates at the accepting edge, and the result is shown in the next cycle,
// during which busy is high.
// After reset the queue is empty and the first command can be taken at once.
// The result side cannot stall, so nothing is ever held back.
module binary_max_heap_queue_top import hpq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_cmd    i_cmd,
    output logic    busy,
    output logic    o_strobe,
    output t_result o_result
);

    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    logic                    r_strobe;
    t_result                 r_result;
    t_result                 n_result;
    t_cell_cmd               w_cmd;
    logic                    w_accept;
    logic                    w_full;
    logic                    w_empty;
    logic signed [KEY_W-1:0] w_max;
    t_status                 w_status;
    logic signed [KEY_W-1:0] w_key [DEPTH];
    logic                    w_gt  [DEPTH];
    logic                    w_occ [DEPTH];

    assign busy     = r_strobe;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    assign w_accept = start && !busy;
    assign w_full   = (r_count == CNT_W'(DEPTH));
    assign w_empty  = (r_count == '0);

    always_comb begin
        w_cmd.key = i_cmd.key_in;
        w_cmd.ins = w_accept && (i_cmd.action == ACT_INSERT) && !w_full;
        w_cmd.rem = w_accept && (i_cmd.action == ACT_REMOVE) && !w_empty;
    end

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        assign w_occ[gi] = (CNT_W'(gi) < r_count);
        if (gi == 0) begin : g_first
            hpq_cell u_cell (
                .i_clk       (i_clk),
                .i_cmd       (w_cmd),
                .i_occ       (w_occ[gi]),
                .i_left_key  ('0),
                .i_left_gt   (1'b0),
                .i_right_key (w_key[gi+1]),
                .o_key       (w_key[gi]),
                .o_gt        (w_gt[gi])
            );
        end else if (gi == DEPTH - 1) begin : g_last
            hpq_cell u_cell (
                .i_clk       (i_clk),
                .i_cmd       (w_cmd),
                .i_occ       (w_occ[gi]),
                .i_left_key  (w_key[gi-1]),
                .i_left_gt   (w_gt[gi-1]),
                .i_right_key (w_key[gi]),
                .o_key       (w_key[gi]),
                .o_gt        (w_gt[gi])
            );
        end else begin : g_mid
            hpq_cell u_cell (
                .i_clk       (i_clk),
                .i_cmd       (w_cmd),
                .i_occ       (w_occ[gi]),
                .i_left_key  (w_key[gi-1]),
                .i_left_gt   (w_gt[gi-1]),
                .i_right_key (w_key[gi+1]),
                .o_key       (w_key[gi]),
                .o_gt        (w_gt[gi])
            );
        end
    end

    always_comb begin
        n_count  = r_count;
        w_max    = w_key[0];
        w_status = ST_OK;
        if (i_cmd.action == ACT_INSERT) begin
            if (w_full) begin
                w_status = ST_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
                if (w_empty || (i_cmd.key_in > w_key[0])) begin
                    w_max = i_cmd.key_in;
                end
            end
        end else begin
            if (w_empty) begin
                w_status = ST_EMPTY;
            end else begin
                n_count = r_count - CNT_W'(1);
                w_max   = w_key[1];
            end
        end
        n_result.max_valid   = (n_count != '0);
        n_result.max_key     = n_result.max_valid ? w_max : '0;
        n_result.entry_count = ECNT_W'(n_count);
        n_result.status      = w_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_accept;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= n_result;
        end
    end

endmodule

/* rtl/hpq_cell.sv */
// One cell of the sorted key row: it holds one key and trades it with its neighbors.
// Depends on hpq_pkg for the key width and the broadcast command struct.
module hpq_cell import hpq_pkg::*; (
    input  logic                    i_clk,
    input  t_cell_cmd               i_cmd,
    input  logic                    i_occ,
    input  logic signed [KEY_W-1:0] i_left_key,
    input  logic                    i_left_gt,
    input  logic signed [KEY_W-1:0] i_right_key,
    output logic signed [KEY_W-1:0] o_key,
    output logic                    o_gt
);

    logic signed [KEY_W-1:0] r_key;
    logic signed [KEY_W-1:0] n_key;

    assign o_gt  = !i_occ || (i_cmd.key > r_key);
    assign o_key = r_key;

    always_comb begin
        n_key = r_key;
        if (i_cmd.ins && o_gt) begin
            n_key = i_left_gt ? i_left_key : i_cmd.key;
        end else if (i_cmd.rem) begin
            n_key = i_right_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

/* rtl/hpq_checker.sv */
// Port-level checks for the max priority queue, bound to the top level.
// Depends on hpq_pkg and binary_max_heap_queue_top.
module hpq_checker import hpq_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input logic    busy,
    input logic    o_strobe,
    input t_result o_result
);

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_strobe)
        else $error("A transaction did not produce a result in the next cycle.");

    a_valid_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.max_valid == (o_result.entry_count != '0)))
        else $error("The valid flag disagrees with the entry count.");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status == ST_FULL) |->
            (o_result.entry_count == ECNT_W'(DEPTH)))
        else $error("An overflow was reported while the queue was not full.");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status == ST_EMPTY) |->
            (!o_result.max_valid && o_result.max_key == '0))
        else $error("An underflow was reported with a nonempty queue.");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.status == ST_OK || o_result.status == ST_FULL ||
                      o_result.status == ST_EMPTY))
        else $error("The result carries an unknown status code.");

endmodule

bind binary_max_heap_queue_top hpq_checker u_hpq_checker (.*);
